>>> design/bruq_pkg.sv
// ----------------------------------------------------------------------------
// Buffered UART queue service package
// Shared constants, command codes and the structures passed between the
// queue controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bruq_pkg;

  // Ring geometry: each port owns QUEUE_DEPTH slots in each store.
  localparam int QUEUE_DEPTH = 256;
  localparam int PORT_COUNT  = 3;
  localparam int STORE_DEPTH = PORT_COUNT * QUEUE_DEPTH;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PSEL_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int PORT_W = 2;
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;

  // Item commands; the fourth code is a no-operation.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 2'd0,
    CMD_GET     = 2'd1,
    CMD_SERVICE = 2'd2
  } cmd_t;

  // One access to a byte store: a write and a read in the same cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Per-item outcome, registered when the item is taken.
  typedef struct packed {
    logic done;
    logic get_ok;
    logic send_ok;
    logic tx_en;
    logic clr;
    logic avail;
  } status_t;

  // Advance a ring index, wrapping at the queue depth.
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  // Flat store address of slot idx of port p.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [PSEL_W-1:0] p,
                                                  input logic [IDX_W-1:0]  idx);
    logic [ADDR_W-1:0] res;
    res = ADDR_W'(p) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/bruq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module bruq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 768,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/bruq_queue_ctrl.sv
// ----------------------------------------------------------------------------
// Queue controller
// Holds the ring indices, transmit enables and counters, decides the store
// accesses for a taken item and registers the outcome of that item.
// ----------------------------------------------------------------------------
`default_nettype none

module bruq_queue_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic [bruq_pkg::CMD_W-1:0]    command,
  input  wire logic [bruq_pkg::PORT_W-1:0]   port,
  input  wire logic [bruq_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          tx_ready,
  input  wire logic                          rx_ready,
  input  wire logic                          line_error,
  output bruq_pkg::ram_req_t                 rx_req,
  output bruq_pkg::ram_req_t                 tx_req,
  output bruq_pkg::status_t                  status,
  output logic      [bruq_pkg::CNT_W-1:0]    ok_total,
  output logic      [bruq_pkg::CNT_W-1:0]    err_total
);

  import bruq_pkg::*;

  logic [IDX_W-1:0] rx_wi [PORT_COUNT];
  logic [IDX_W-1:0] rx_ri [PORT_COUNT];
  logic [IDX_W-1:0] tx_wi [PORT_COUNT];
  logic [IDX_W-1:0] tx_ri [PORT_COUNT];
  logic [PORT_COUNT-1:0] tx_flag;

  logic [PSEL_W-1:0] pidx;
  logic              in_range;
  logic [IDX_W-1:0]  cur_rx_wi, cur_rx_ri, cur_tx_wi, cur_tx_ri;
  logic [IDX_W-1:0]  rx_wi_next, rx_ri_next, tx_wi_next, tx_ri_next;
  logic              rx_empty, rx_full, tx_empty, tx_full;
  logic              push_tx, pop_rx, tx_try, pop_tx, push_rx, drop_rx, lerr;
  logic              flag_next;
  status_t           status_next;

  // Current indices of the addressed port.
  always_comb begin
    pidx      = PSEL_W'(port);
    in_range  = (int'(port) < PORT_COUNT);
    cur_rx_wi = rx_wi[pidx];
    cur_rx_ri = rx_ri[pidx];
    cur_tx_wi = tx_wi[pidx];
    cur_tx_ri = tx_ri[pidx];
    rx_empty  = (cur_rx_wi == cur_rx_ri);
    tx_empty  = (cur_tx_wi == cur_tx_ri);
    rx_full   = (ring_next(cur_rx_wi) == cur_rx_ri);
    tx_full   = (ring_next(cur_tx_wi) == cur_tx_ri);
  end

  // Command decode: transmit first, then receive, then line error.
  always_comb begin
    push_tx = in_range && (command == CMD_PUT) && !tx_full;
    pop_rx  = in_range && (command == CMD_GET) && !rx_empty;
    tx_try  = in_range && (command == CMD_SERVICE) && tx_ready && tx_flag[pidx];
    pop_tx  = tx_try && !tx_empty;
    push_rx = in_range && (command == CMD_SERVICE) && rx_ready && !rx_full;
    drop_rx = in_range && (command == CMD_SERVICE) && rx_ready && rx_full;
    lerr    = in_range && (command == CMD_SERVICE) && line_error;

    rx_wi_next = push_rx ? ring_next(cur_rx_wi) : cur_rx_wi;
    rx_ri_next = pop_rx  ? ring_next(cur_rx_ri) : cur_rx_ri;
    tx_wi_next = push_tx ? ring_next(cur_tx_wi) : cur_tx_wi;
    tx_ri_next = pop_tx  ? ring_next(cur_tx_ri) : cur_tx_ri;

    if (push_tx) begin
      flag_next = 1'b1;
    end else if (tx_try && tx_empty) begin
      flag_next = 1'b0;
    end else begin
      flag_next = in_range && tx_flag[pidx];
    end

    status_next.done    = push_tx || pop_rx;
    status_next.get_ok  = pop_rx;
    status_next.send_ok = pop_tx;
    status_next.tx_en   = in_range && flag_next;
    status_next.clr     = lerr;
    status_next.avail   = in_range && (rx_wi_next != rx_ri_next);
  end

  // Store accesses for the taken item.
  always_comb begin
    rx_req.we    = take && push_rx;
    rx_req.waddr = slot_addr(pidx, cur_rx_wi);
    rx_req.wdata = data_byte;
    rx_req.re    = take && pop_rx;
    rx_req.raddr = slot_addr(pidx, cur_rx_ri);
    tx_req.we    = take && push_tx;
    tx_req.waddr = slot_addr(pidx, cur_tx_wi);
    tx_req.wdata = data_byte;
    tx_req.re    = take && pop_tx;
    tx_req.raddr = slot_addr(pidx, cur_tx_ri);
  end

  // Index, enable and counter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        rx_wi[i] <= '0;
        rx_ri[i] <= '0;
        tx_wi[i] <= '0;
        tx_ri[i] <= '0;
      end
      tx_flag   <= '0;
      ok_total  <= '0;
      err_total <= '0;
      status    <= '0;
    end else if (take) begin
      if (in_range) begin
        rx_wi[pidx]   <= rx_wi_next;
        rx_ri[pidx]   <= rx_ri_next;
        tx_wi[pidx]   <= tx_wi_next;
        tx_ri[pidx]   <= tx_ri_next;
        tx_flag[pidx] <= flag_next;
      end
      ok_total  <= ok_total + CNT_W'(push_rx);
      err_total <= err_total + CNT_W'({drop_rx && lerr, drop_rx ^ lerr});
      status    <= status_next;
    end
  end

  // A get and a transmit pop never come from the same item.
  assert property (@(posedge clk) disable iff (rst) !(status.get_ok && status.send_ok))
    else $error("get and transmit pop reported together");

  // The error total grows by at most two per item.
  assert property (@(posedge clk) disable iff (rst)
                   $past(!rst) |-> (err_total - $past(err_total)) <= CNT_W'(2))
    else $error("error total jumped by more than two");

  // Counters move only when an item is taken.
  assert property (@(posedge clk) disable iff (rst)
                   $past(!rst) && !$past(take) |-> $stable(ok_total) && $stable(err_total))
    else $error("counter changed without a taken item");

endmodule

`default_nettype wire

>>> design/buffered_uart_queue_service.sv
// ----------------------------------------------------------------------------
// Buffered UART queue service
// Per-port receive and transmit ring queues held in two byte RAMs.
//
// Input channel: in_valid / in_stall with command, port, data_byte and the
// line status bits. Output channel: out_valid / out_stall with one result
// per input item. A transfer happens on a rising edge with valid high and
// stall low.
// An item is taken in the idle cycle: the indices are updated and the store
// read is issued at that edge. In the response state the result register is
// loaded from the registered RAM read data once it is free, and only then
// can the next item be taken: the block does not take a new item before
// the result of the last one is loaded.
// While out_stall is high the result register holds its item; one further
// item is still taken and waits with its read data until the register
// frees up. Reset clears the indices, enables and counters at once; the
// stores need no clearing pass, as only written slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module buffered_uart_queue_service (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bruq_pkg::CMD_W-1:0]  command,
  input  wire logic [bruq_pkg::PORT_W-1:0] port,
  input  wire logic [bruq_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        tx_ready,
  input  wire logic                        rx_ready,
  input  wire logic                        line_error,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             done_res,
  output logic      [bruq_pkg::BYTE_W-1:0] read_byte,
  output logic                             send_valid,
  output logic      [bruq_pkg::BYTE_W-1:0] send_byte,
  output logic                             tx_irq_enable,
  output logic                             clear_status,
  output logic                             rx_available,
  output logic      [bruq_pkg::CNT_W-1:0]  ok_count,
  output logic      [bruq_pkg::CNT_W-1:0]  error_count
);

  import bruq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t            state;
  logic              take;
  ram_req_t          rx_req, tx_req;
  status_t           status;
  logic [CNT_W-1:0]  ok_total, err_total;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;
  logic              load;

  // Input transfer: one item in flight at a time.
  assign in_stall = (state != ST_IDLE);
  assign take     = in_valid && !in_stall;
  assign load     = (state == ST_RESP) && (!out_valid || !out_stall);

  bruq_queue_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .command    (command),
    .port       (port),
    .data_byte  (data_byte),
    .tx_ready   (tx_ready),
    .rx_ready   (rx_ready),
    .line_error (line_error),
    .rx_req     (rx_req),
    .tx_req     (tx_req),
    .status     (status),
    .ok_total   (ok_total),
    .err_total  (err_total)
  );

  // Receive byte store.
  bruq_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_rdata)
  );

  // Transmit byte store.
  bruq_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_rdata)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (take) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (load) begin
            out_valid     <= 1'b1;
            done_res      <= status.done;
            read_byte     <= status.get_ok ? rx_rdata : '0;
            send_valid    <= status.send_ok;
            send_byte     <= status.send_ok ? tx_rdata : '0;
            tx_irq_enable <= status.tx_en;
            clear_status  <= status.clr;
            rx_available  <= status.avail;
            ok_count      <= ok_total;
            error_count   <= err_total;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A taken item is always followed by a stalled input the next cycle.
  assert property (@(posedge clk) disable iff (rst) take |=> in_stall)
    else $error("input taken while an item is still in flight");

  // A new result only appears after the response cycle.
  assert property (@(posedge clk) disable iff (rst)
                   $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result raised outside the response cycle");

  // A shown send byte is zero whenever no byte is sent.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !send_valid |-> send_byte == '0)
    else $error("send byte set without a send");

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Buffered UART queue service testbench
// Drives command items into the block and checks every result against a
// local model of the per-port transmit and receive rings or a hand-written
// table result. The stimulus opens with a table of hand-picked items, then
// fills and drains the rings of single ports, with random items mixed in.
// The sender idles in random bursts and the receiver stalls on its own
// pattern, holding off for a long stretch from time to time.
// ----------------------------------------------------------------------------
module tb;
  import bruq_pkg::*;

  // The unused command code and the port number that has no queues.
  localparam logic [CMD_W-1:0]  CMD_NOP   = 2'd3;
  localparam logic [PORT_W-1:0] PORT_NONE = 2'd3;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] rbyte;
    logic              sval;
    logic [BYTE_W-1:0] sbyte;
    logic              txen;
    logic              clr;
    logic              avail;
    logic [CNT_W-1:0]  ok;
    logic [CNT_W-1:0]  err;
  } reply_t;

  // One item; stat is {tx_ready, rx_ready, line_error}. Where typed is set,
  // res holds the result written into the table by hand.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] prt;
    logic [BYTE_W-1:0] dat;
    logic [2:0]        stat;
    logic              typed;
    reply_t            res;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command    = '0;
  logic [PORT_W-1:0] port       = '0;
  logic [BYTE_W-1:0] data_byte  = '0;
  logic              tx_ready   = 1'b0;
  logic              rx_ready   = 1'b0;
  logic              line_error = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic              done_res;
  logic [BYTE_W-1:0] read_byte;
  logic              send_valid;
  logic [BYTE_W-1:0] send_byte;
  logic              tx_irq_enable;
  logic              clear_status;
  logic              rx_available;
  logic [CNT_W-1:0]  ok_count;
  logic [CNT_W-1:0]  error_count;

  // Model state: ring contents, indices, transmit enables and counters.
  logic [BYTE_W-1:0] rx_ring [PORT_COUNT][QUEUE_DEPTH];
  logic [BYTE_W-1:0] tx_ring [PORT_COUNT][QUEUE_DEPTH];
  logic [IDX_W-1:0]  rx_wr [PORT_COUNT] = '{default: '0};
  logic [IDX_W-1:0]  rx_rd [PORT_COUNT] = '{default: '0};
  logic [IDX_W-1:0]  tx_wr [PORT_COUNT] = '{default: '0};
  logic [IDX_W-1:0]  tx_rd [PORT_COUNT] = '{default: '0};
  logic              tx_on [PORT_COUNT] = '{default: 1'b0};
  logic [CNT_W-1:0]  ok_total  = '0;
  logic [CNT_W-1:0]  err_total = '0;

  stim_t  stim_q[$];
  reply_t awaited_replies[$];
  int     items_taken = 0;
  int     fail_count  = 0;
  int     rcv_cycle   = 0;

  buffered_uart_queue_service dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .port          (port),
    .data_byte     (data_byte),
    .tx_ready      (tx_ready),
    .rx_ready      (rx_ready),
    .line_error    (line_error),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .done_res      (done_res),
    .read_byte     (read_byte),
    .send_valid    (send_valid),
    .send_byte     (send_byte),
    .tx_irq_enable (tx_irq_enable),
    .clear_status  (clear_status),
    .rx_available  (rx_available),
    .ok_count      (ok_count),
    .error_count   (error_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Next slot of a ring, wrapping at the queue depth.
  function automatic logic [IDX_W-1:0] slot_after(logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + 1'b1;
    end
    return n;
  endfunction

  // Applies one item to the model state and returns the result it gives.
  function automatic reply_t serve_item(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] prt,
                                        logic [BYTE_W-1:0] dat, logic txr, logic rxr,
                                        logic lerr);
    reply_t           r;
    logic [IDX_W-1:0] nx;
    r = '0;
    if (prt < PORT_COUNT) begin
      case (cmd)
        CMD_PUT: begin
          nx = slot_after(tx_wr[prt]);
          if (nx != tx_rd[prt]) begin
            tx_ring[prt][tx_wr[prt]] = dat;
            tx_wr[prt] = nx;
            tx_on[prt] = 1'b1;
            r.done = 1'b1;
          end
        end
        CMD_GET: begin
          if (rx_wr[prt] != rx_rd[prt]) begin
            r.done  = 1'b1;
            r.rbyte = rx_ring[prt][rx_rd[prt]];
            rx_rd[prt] = slot_after(rx_rd[prt]);
          end
        end
        CMD_SERVICE: begin
          // Transmit first: send the next byte, or drop the enable when empty.
          if (txr && tx_on[prt]) begin
            if (tx_wr[prt] != tx_rd[prt]) begin
              r.sval  = 1'b1;
              r.sbyte = tx_ring[prt][tx_rd[prt]];
              tx_rd[prt] = slot_after(tx_rd[prt]);
            end else begin
              tx_on[prt] = 1'b0;
            end
          end
          // Then receive; a full ring drops the byte and counts an error.
          if (rxr) begin
            nx = slot_after(rx_wr[prt]);
            if (nx != rx_rd[prt]) begin
              rx_ring[prt][rx_wr[prt]] = dat;
              rx_wr[prt] = nx;
              ok_total = ok_total + 1'b1;
            end else begin
              err_total = err_total + 1'b1;
            end
          end
          if (lerr) begin
            err_total = err_total + 1'b1;
            r.clr = 1'b1;
          end
        end
        default: ;
      endcase
      r.txen  = tx_on[prt];
      r.avail = (rx_wr[prt] != rx_rd[prt]);
    end
    r.ok  = ok_total;
    r.err = err_total;
    return r;
  endfunction

  // Hand-written result; flags is {done, send_valid, tx_irq_enable,
  // clear_status, rx_available}.
  function automatic reply_t reply_of(logic [4:0] flags, logic [BYTE_W-1:0] rb,
                                      logic [BYTE_W-1:0] sb, logic [CNT_W-1:0] ok,
                                      logic [CNT_W-1:0] err);
    return '{flags[4], rb, flags[3], sb, flags[2], flags[1], flags[0], ok, err};
  endfunction

  function automatic stim_t port_item(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] prt);
    stim_t s;
    s      = '0;
    s.cmd  = cmd;
    s.prt  = prt;
    s.dat  = BYTE_W'($urandom_range(0, 255));
    s.stat = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              ($urandom_range(0, 3) == 0)};
    return s;
  endfunction

  // Any command on any port, weighted towards the real commands and ports.
  function automatic stim_t mixed_item();
    int                r;
    logic [CMD_W-1:0]  c;
    logic [PORT_W-1:0] p;
    r = int'($urandom_range(0, 15));
    if (r < 5) begin
      c = CMD_PUT;
    end else if (r < 9) begin
      c = CMD_GET;
    end else if (r < 15) begin
      c = CMD_SERVICE;
    end else begin
      c = CMD_NOP;
    end
    if ($urandom_range(0, 9) == 0) begin
      p = PORT_NONE;
    end else begin
      p = PORT_W'($urandom_range(0, PORT_COUNT - 1));
    end
    return port_item(c, p);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result transfers are checked against the oldest expectation; input
  // transfers are run through the model and queued.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{done_res, read_byte, send_valid, send_byte, tx_irq_enable,
                clear_status, rx_available, ok_count, error_count};
        if (awaited_replies.size() == 0) begin
          $display("%0t: result transfer with none expected, actual %0h", $time, got);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("done_res", 32'(want.done), 32'(got.done));
          check_field("read_byte", 32'(want.rbyte), 32'(got.rbyte));
          check_field("send_valid", 32'(want.sval), 32'(got.sval));
          check_field("send_byte", 32'(want.sbyte), 32'(got.sbyte));
          check_field("tx_irq_enable", 32'(want.txen), 32'(got.txen));
          check_field("clear_status", 32'(want.clr), 32'(got.clr));
          check_field("rx_available", 32'(want.avail), 32'(got.avail));
          check_field("ok_count", want.ok, got.ok);
          check_field("error_count", want.err, got.err);
        end
      end
      if (in_valid && !in_stall) begin
        want = serve_item(command, port, data_byte, tx_ready, rx_ready, line_error);
        if (stim_q[items_taken].typed) begin
          want = stim_q[items_taken].res;
        end
        awaited_replies.push_back(want);
        items_taken++;
      end
    end
  end

  // Receiver: windows of no stall, random stall and a fixed pattern, with a
  // long hold-off now and then so that the block backs up into its input.
  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    if (rcv_cycle % 2500 >= 2380) begin
      out_stall <= 1'b1;
    end else begin
      case ((rcv_cycle / 400) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= (rcv_cycle % 5 < 2);
        default: out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  initial begin
    stim_t dir_tab [20];
    stim_t s;
    logic [PORT_W-1:0] p;
    int burst_left;
    int gap;

    // Opening items, from reset: empty rings, the enable being set and
    // cleared, receive with a line error, an absent port, the unused
    // command, and status bits that put and get must ignore.
    dir_tab = '{
      '{CMD_GET, 2'd0, 8'h00, 3'b000, 1'b1,
        reply_of(5'b00000, 8'h00, 8'h00, 32'd0, 32'd0)},
      '{CMD_SERVICE, 2'd0, 8'h00, 3'b100, 1'b1,
        reply_of(5'b00000, 8'h00, 8'h00, 32'd0, 32'd0)},
      '{CMD_PUT, 2'd0, 8'hFF, 3'b000, 1'b1,
        reply_of(5'b10100, 8'h00, 8'h00, 32'd0, 32'd0)},
      '{CMD_PUT, 2'd1, 8'h00, 3'b000, 1'b1,
        reply_of(5'b10100, 8'h00, 8'h00, 32'd0, 32'd0)},
      '{CMD_PUT, 2'd2, 8'hA5, 3'b000, 1'b1,
        reply_of(5'b10100, 8'h00, 8'h00, 32'd0, 32'd0)},
      '{CMD_SERVICE, 2'd0, 8'h00, 3'b100, 1'b1,
        reply_of(5'b01100, 8'h00, 8'hFF, 32'd0, 32'd0)},
      '{CMD_SERVICE, 2'd0, 8'h00, 3'b100, 1'b1,
        reply_of(5'b00000, 8'h00, 8'h00, 32'd0, 32'd0)},
      '{CMD_SERVICE, 2'd1, 8'hFF, 3'b011, 1'b1,
        reply_of(5'b00111, 8'h00, 8'h00, 32'd1, 32'd1)},
      '{CMD_GET, 2'd1, 8'h00, 3'b000, 1'b1,
        reply_of(5'b10100, 8'hFF, 8'h00, 32'd1, 32'd1)},
      '{CMD_PUT, PORT_NONE, 8'h5A, 3'b111, 1'b1,
        reply_of(5'b00000, 8'h00, 8'h00, 32'd1, 32'd1)},
      '{CMD_NOP, 2'd2, 8'h3C, 3'b111, 1'b1,
        reply_of(5'b00100, 8'h00, 8'h00, 32'd1, 32'd1)},
      '{CMD_PUT, 2'd0, 8'h81, 3'b111, 1'b1,
        reply_of(5'b10100, 8'h00, 8'h00, 32'd1, 32'd1)},
      '{CMD_GET, 2'd2, 8'h00, 3'b111, 1'b1,
        reply_of(5'b00100, 8'h00, 8'h00, 32'd1, 32'd1)},
      '{CMD_SERVICE, 2'd2, 8'h00, 3'b001, 1'b1,
        reply_of(5'b00110, 8'h00, 8'h00, 32'd1, 32'd2)},
      '{CMD_SERVICE, 2'd2, 8'h00, 3'b110, 1'b1,
        reply_of(5'b01101, 8'h00, 8'hA5, 32'd2, 32'd2)},
      '{CMD_GET, 2'd2, 8'h00, 3'b000, 1'b1,
        reply_of(5'b10100, 8'h00, 8'h00, 32'd2, 32'd2)},
      '{CMD_SERVICE, 2'd2, 8'h00, 3'b100, 1'b1,
        reply_of(5'b00000, 8'h00, 8'h00, 32'd2, 32'd2)},
      '{CMD_SERVICE, 2'd0, 8'h7E, 3'b111, 1'b1,
        reply_of(5'b01111, 8'h00, 8'h81, 32'd3, 32'd3)},
      '{CMD_GET, 2'd0, 8'h00, 3'b000, 1'b0, '0},
      '{CMD_NOP, PORT_NONE, 8'hFF, 3'b111, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      stim_q.push_back(dir_tab[i]);
    end
    repeat (250) stim_q.push_back(mixed_item());

    // Fill one transmit ring past full, then drain it until the enable drops.
    p = PORT_W'($urandom_range(0, PORT_COUNT - 1));
    repeat (300) begin
      s = port_item(CMD_PUT, p);
      if ($urandom_range(0, 19) == 0) s = mixed_item();
      stim_q.push_back(s);
    end
    repeat (280) begin
      s = port_item(CMD_SERVICE, p);
      s.stat[2] = 1'b1;
      if ($urandom_range(0, 19) == 0) s = mixed_item();
      stim_q.push_back(s);
    end

    // Overflow one receive ring, then read it empty.
    p = PORT_W'($urandom_range(0, PORT_COUNT - 1));
    repeat (300) begin
      s = port_item(CMD_SERVICE, p);
      s.stat[1] = 1'b1;
      if ($urandom_range(0, 19) == 0) s = mixed_item();
      stim_q.push_back(s);
    end
    repeat (280) begin
      s = port_item(CMD_GET, p);
      if ($urandom_range(0, 19) == 0) s = mixed_item();
      stim_q.push_back(s);
    end
    repeat (50) stim_q.push_back(mixed_item());

    // Sender: bursts of transfers with random gaps, none in a middle stretch.
    burst_left = 0;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = int'($urandom_range(1, 24));
        gap = (i >= 700 && i < 900) ? 0 : int'($urandom_range(1, 8));
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid   <= 1'b1;
      command    <= stim_q[i].cmd;
      port       <= stim_q[i].prt;
      data_byte  <= stim_q[i].dat;
      {tx_ready, rx_ready, line_error} <= stim_q[i].stat;
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;

    while (items_taken != stim_q.size() || awaited_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/bruq_pkg.sv
design/bruq_ram.sv
design/bruq_queue_ctrl.sv
design/buffered_uart_queue_service.sv
tb/tb.sv
